// ===== src/crvs_pkg.sv =====
package crvs_pkg;

	localparam int unsigned RECORD_SLOTS = 2;
	localparam int unsigned REC_LEN      = 20;
	localparam int unsigned CRC_LEN      = 16;

	localparam logic [4:0]  LAST_POS     = 5'(REC_LEN - 1);
	localparam logic [4:0]  CRC_END_POS  = 5'(CRC_LEN);
	localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
	localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
	localparam logic [7:0]  SCHEMA_VALUE = 8'd1;
	localparam logic [31:0] MIN_VERSION_RESET = 32'd1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_MAGIC = 3'd1,
		ST_BAD_SCHEMA = 3'd2,
		ST_CRC_FAIL  = 3'd3,
		ST_VER_LOW   = 3'd4
	} crvs_status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [2:0] slot_index;
		logic       first_of_pass;
	} crvs_in_t;

	typedef struct packed {
		logic        record_ok;
		logic [2:0]  status;
		logic [31:0] record_version;
		logic [7:0]  temperature_high;
		logic [7:0]  humidity_high;
		logic [15:0] gas_high;
		logic [7:0]  temperature_rise;
		logic [15:0] gas_rise;
		logic        best_found;
		logic [2:0]  best_slot;
		logic [31:0] best_version;
	} crvs_out_t;

	// per-item view of the record parser, seen by the selection logic
	typedef struct packed {
		logic         first;
		logic         last;
		crvs_status_t status;
		logic [31:0]  version;
		logic [31:0]  version_raw;
		logic [7:0]   temperature_high;
		logic [7:0]   humidity_high;
		logic [15:0]  gas_high;
		logic [7:0]   temperature_rise;
		logic [15:0]  gas_rise;
	} crvs_rec_t;

	function automatic logic [7:0] magic_byte(logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0:    r = 8'h4C;
			2'd1:    r = 8'h54;
			2'd2:    r = 8'h48;
			default: r = 8'h52;
		endcase
		return r;
	endfunction

	// reflected CRC-32, one byte unrolled over eight bit steps
	function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== src/crvs_record.sv =====
module crvs_record (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic [31:0]          min_version,
	output crvs_pkg::crvs_rec_t  rec
);

	logic [4:0]  pos_q;
	logic [31:0] crc_q;
	logic        magic_q;
	logic        schema_q;
	logic [31:0] version_q;
	logic [7:0]  temp_high_q;
	logic [7:0]  hum_high_q;
	logic [15:0] gas_high_q;
	logic [7:0]  temp_rise_q;
	logic [15:0] gas_rise_q;
	logic [23:0] stored_q;

	logic [31:0] crc_base;
	logic [31:0] crc_next;
	logic [31:0] stored;
	logic        show;
	crvs_pkg::crvs_status_t status;

	always_comb begin
		crc_base = (pos_q == 5'd0) ? crvs_pkg::ALL_ONES : crc_q;
		crc_next = crvs_pkg::crc_byte(crc_base, data_byte);
		stored   = {data_byte, stored_q};

		if (!magic_q) begin
			status = crvs_pkg::ST_BAD_MAGIC;
		end else if (!schema_q) begin
			status = crvs_pkg::ST_BAD_SCHEMA;
		end else if (stored != ~crc_q) begin
			status = crvs_pkg::ST_CRC_FAIL;
		end else if (version_q < min_version) begin
			status = crvs_pkg::ST_VER_LOW;
		end else begin
			status = crvs_pkg::ST_OK;
		end
		show = (status == crvs_pkg::ST_OK) || (status == crvs_pkg::ST_VER_LOW);

		rec.first            = (pos_q == 5'd0);
		rec.last             = (pos_q == crvs_pkg::LAST_POS);
		rec.status           = status;
		rec.version_raw      = version_q;
		rec.version          = show ? version_q   : 32'd0;
		rec.temperature_high = show ? temp_high_q : 8'd0;
		rec.humidity_high    = show ? hum_high_q  : 8'd0;
		rec.gas_high         = show ? gas_high_q  : 16'd0;
		rec.temperature_rise = show ? temp_rise_q : 8'd0;
		rec.gas_rise         = show ? gas_rise_q  : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 5'd0;
			crc_q    <= crvs_pkg::ALL_ONES;
			magic_q  <= 1'b1;
			schema_q <= 1'b1;
		end else if (accept) begin
			if (pos_q == crvs_pkg::LAST_POS) begin
				pos_q    <= 5'd0;
				crc_q    <= crvs_pkg::ALL_ONES;
				magic_q  <= 1'b1;
				schema_q <= 1'b1;
			end else begin
				pos_q <= pos_q + 5'd1;
				if (pos_q < crvs_pkg::CRC_END_POS) begin
					crc_q <= crc_next;
				end
				if (pos_q < 5'd4) begin
					magic_q <= magic_q & (data_byte == crvs_pkg::magic_byte(pos_q[1:0]));
				end
				if (pos_q == 5'd4) begin
					schema_q <= (data_byte == crvs_pkg::SCHEMA_VALUE);
				end
			end
		end
	end

	// every field byte is written once per record before it is read
	always_ff @(posedge clk) begin
		if (accept) begin
			case (pos_q)
				5'd5:    version_q[7:0]    <= data_byte;
				5'd6:    version_q[15:8]   <= data_byte;
				5'd7:    version_q[23:16]  <= data_byte;
				5'd8:    version_q[31:24]  <= data_byte;
				5'd9:    temp_high_q       <= data_byte;
				5'd10:   hum_high_q        <= data_byte;
				5'd11:   gas_high_q[7:0]   <= data_byte;
				5'd12:   gas_high_q[15:8]  <= data_byte;
				5'd13:   temp_rise_q       <= data_byte;
				5'd14:   gas_rise_q[7:0]   <= data_byte;
				5'd15:   gas_rise_q[15:8]  <= data_byte;
				5'd16:   stored_q[7:0]     <= data_byte;
				5'd17:   stored_q[15:8]    <= data_byte;
				5'd18:   stored_q[23:16]   <= data_byte;
				default: ;
			endcase
		end
	end

endmodule

// ===== src/config_record_validate_select.sv =====
// Configuration record checker with best-slot selection.
//
// Byte channel (byte_valid / byte_stall / byte_item): one record byte per
// item, byte 0 first, 20 bytes to a record, tagged with its slot number.
// first_of_pass on byte 0 clears the current best selection.
// Result channel (res_valid / res_stall / res_item): one item per record,
// registered, valid the cycle after the 20th byte is accepted. It carries
// the check status, the decoded fields and the best slot after this record.
// Bytes 0..18 of a record produce no result.
// cfg_we / cfg_wdata write min_version (reset value 1).
// Throughput: one byte per cycle when byte_stall is low. The CRC-32 step over
// a whole byte and the field capture finish in the accepting cycle; the final
// checks and the selection update feed the result register directly.
// Stall: a pending result held by res_stall blocks only the last byte of
// the next record; bytes 0..18 keep flowing into the parser.
// Reset: parser restarts at byte 0, no best slot is held, the result
// register is empty.
module config_record_validate_select (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  crvs_pkg::crvs_in_t   byte_item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output crvs_pkg::crvs_out_t  res_item,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_wdata
);

	logic [31:0]         min_version_q;
	logic                accept;
	crvs_pkg::crvs_rec_t rec;

	logic        best_valid_q;
	logic [2:0]  best_slot_q;
	logic [31:0] best_version_q;
	logic        best_valid_n;
	logic [2:0]  best_slot_n;
	logic [31:0] best_version_n;
	logic        win;
	logic        load;

	logic               res_valid_q;
	crvs_pkg::crvs_out_t res_q;

	assign byte_stall = res_valid_q && res_stall && rec.last;
	assign accept     = byte_valid && !byte_stall;
	assign load       = accept && rec.last;

	crvs_record u_record (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (byte_item.data_byte),
		.min_version (min_version_q),
		.rec         (rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_version_q <= crvs_pkg::MIN_VERSION_RESET;
		end else if (cfg_we) begin
			min_version_q <= cfg_wdata;
		end
	end

	always_comb begin
		win = (rec.status == crvs_pkg::ST_OK)
			&& ({1'b0, byte_item.slot_index} < 4'(crvs_pkg::RECORD_SLOTS))
			&& (!best_valid_q || (rec.version_raw > best_version_q));
		best_valid_n   = best_valid_q;
		best_slot_n    = best_slot_q;
		best_version_n = best_version_q;
		if (rec.first && byte_item.first_of_pass) begin
			best_valid_n   = 1'b0;
			best_slot_n    = 3'd0;
			best_version_n = 32'd0;
		end else if (rec.last && win) begin
			best_valid_n   = 1'b1;
			best_slot_n    = byte_item.slot_index;
			best_version_n = rec.version_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q   <= 1'b0;
			best_slot_q    <= 3'd0;
			best_version_q <= 32'd0;
		end else if (accept) begin
			best_valid_q   <= best_valid_n;
			best_slot_q    <= best_slot_n;
			best_version_q <= best_version_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.record_ok        <= (rec.status == crvs_pkg::ST_OK);
			res_q.status           <= rec.status;
			res_q.record_version   <= rec.version;
			res_q.temperature_high <= rec.temperature_high;
			res_q.humidity_high    <= rec.humidity_high;
			res_q.gas_high         <= rec.gas_high;
			res_q.temperature_rise <= rec.temperature_rise;
			res_q.gas_rise         <= rec.gas_rise;
			res_q.best_found       <= best_valid_n;
			res_q.best_slot        <= best_slot_n;
			res_q.best_version     <= best_version_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

// ===== src/crvs_checker.sv =====
module crvs_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_stall,
	input crvs_pkg::crvs_out_t  res_item
);

	// a held result does not move
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.record_ok == (res_item.status == crvs_pkg::ST_OK))
		else $error("record_ok disagrees with status");

	a_no_best: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.best_found
		|-> res_item.best_slot == 3'd0 && res_item.best_version == 32'd0)
		else $error("cleared selection shows a slot");

	// failed structure or CRC reports no decoded fields
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_item.status == crvs_pkg::ST_BAD_MAGIC
			|| res_item.status == crvs_pkg::ST_BAD_SCHEMA
			|| res_item.status == crvs_pkg::ST_CRC_FAIL)
		|-> res_item.record_version == 32'd0 && res_item.gas_high == 16'd0
			&& res_item.gas_rise == 16'd0 && res_item.temperature_high == 8'd0)
		else $error("failed record shows fields");

	a_ok_best: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.best_found
		|-> res_item.best_slot < 3'(crvs_pkg::RECORD_SLOTS)
			|| crvs_pkg::RECORD_SLOTS > 7)
		else $error("best slot out of range");

endmodule

bind config_record_validate_select crvs_checker u_crvs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_item  (res_item)
);

// ===== tb/config_record_validate_select_test.sv =====
`timescale 1ns / 1ps

module config_record_validate_select_test;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned HOLD_CYCLES  = 150;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned MAX_REPORTS  = 10;
	// record tag, byte 0 in the low bits
	localparam logic [31:0] TAG_WORD     = 32'h5248_544C;

	typedef logic [8*crvs_pkg::REC_LEN-1:0] record_t;
	typedef logic [crvs_pkg::REC_LEN-1:0]   pass_mask_t;

	logic                 clk;
	logic                 arst_n;
	logic                 byte_valid;
	logic                 byte_stall;
	crvs_pkg::crvs_in_t   byte_item;
	logic                 res_valid;
	logic                 res_stall;
	crvs_pkg::crvs_out_t  res_item;
	logic                 cfg_we;
	logic [31:0]          cfg_wdata;

	// parser and selection state as the block should hold it
	logic [31:0] min_version_q;
	logic [4:0]  rec_pos;
	logic [31:0] rec_crc;
	logic        magic_ok;
	logic        schema_ok;
	logic [31:0] ver_cap;
	logic [7:0]  temp_hi_cap;
	logic [7:0]  hum_cap;
	logic [15:0] gas_hi_cap;
	logic [7:0]  temp_rise_cap;
	logic [15:0] gas_rise_cap;
	logic [31:0] crc_cap;
	logic        sel_valid;
	logic [2:0]  sel_slot;
	logic [31:0] sel_version;

	crvs_pkg::crvs_out_t expected_records[$];
	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;
	int unsigned gap_pct     = 0;
	int unsigned stall_pct   = 0;
	bit          hold_req    = 1'b0;

	config_record_validate_select u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** config_record_validate_select: FAILED **");
			$finish;
		end
	end

	// reflected CRC-32, data fed LSB first
	function automatic logic [31:0] crc32_step(logic [31:0] crc, logic [7:0] d);
		logic [31:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ d[i];
			c = {1'b0, c[31:1]};
			if (fb)
				c = c ^ crvs_pkg::CRC_POLY;
		end
		return c;
	endfunction

	function automatic void restart_record();
		rec_pos       = '0;
		rec_crc       = crvs_pkg::ALL_ONES;
		magic_ok      = 1'b1;
		schema_ok     = 1'b1;
		ver_cap       = '0;
		temp_hi_cap   = '0;
		hum_cap       = '0;
		gas_hi_cap    = '0;
		temp_rise_cap = '0;
		gas_rise_cap  = '0;
		crc_cap       = '0;
	endfunction

	function automatic void predict_byte(crvs_pkg::crvs_in_t it);
		logic [31:0]            stored;
		crvs_pkg::crvs_status_t st;
		crvs_pkg::crvs_out_t    r;
		logic                   show;
		if (rec_pos == 0 && it.first_of_pass) begin
			sel_valid   = 1'b0;
			sel_slot    = '0;
			sel_version = '0;
		end
		if (rec_pos < crvs_pkg::CRC_LEN)
			rec_crc = crc32_step(rec_crc, it.data_byte);
		if (rec_pos < 4) begin
			if (it.data_byte != TAG_WORD[8*rec_pos +: 8])
				magic_ok = 1'b0;
		end else if (rec_pos == 4) begin
			schema_ok = (it.data_byte == crvs_pkg::SCHEMA_VALUE);
		end else if (rec_pos <= 8) begin
			ver_cap[8*(rec_pos-5) +: 8] = it.data_byte;
		end else if (rec_pos == 9) begin
			temp_hi_cap = it.data_byte;
		end else if (rec_pos == 10) begin
			hum_cap = it.data_byte;
		end else if (rec_pos <= 12) begin
			gas_hi_cap[8*(rec_pos-11) +: 8] = it.data_byte;
		end else if (rec_pos == 13) begin
			temp_rise_cap = it.data_byte;
		end else if (rec_pos <= 15) begin
			gas_rise_cap[8*(rec_pos-14) +: 8] = it.data_byte;
		end else if (rec_pos <= 18) begin
			crc_cap[8*(rec_pos-16) +: 8] = it.data_byte;
		end

		if (rec_pos != crvs_pkg::LAST_POS) begin
			rec_pos = rec_pos + 5'd1;
		end else begin
			stored = {it.data_byte, crc_cap[23:0]};
			if (!magic_ok)
				st = crvs_pkg::ST_BAD_MAGIC;
			else if (!schema_ok)
				st = crvs_pkg::ST_BAD_SCHEMA;
			else if (stored != (rec_crc ^ crvs_pkg::ALL_ONES))
				st = crvs_pkg::ST_CRC_FAIL;
			else if (ver_cap < min_version_q)
				st = crvs_pkg::ST_VER_LOW;
			else
				st = crvs_pkg::ST_OK;
			if (st == crvs_pkg::ST_OK && it.slot_index < crvs_pkg::RECORD_SLOTS &&
				(!sel_valid || ver_cap > sel_version)) begin
				sel_valid   = 1'b1;
				sel_slot    = it.slot_index;
				sel_version = ver_cap;
			end
			show               = (st == crvs_pkg::ST_OK || st == crvs_pkg::ST_VER_LOW);
			r.record_ok        = (st == crvs_pkg::ST_OK);
			r.status           = st;
			r.record_version   = show ? ver_cap : '0;
			r.temperature_high = show ? temp_hi_cap : '0;
			r.humidity_high    = show ? hum_cap : '0;
			r.gas_high         = show ? gas_hi_cap : '0;
			r.temperature_rise = show ? temp_rise_cap : '0;
			r.gas_rise         = show ? gas_rise_cap : '0;
			r.best_found       = sel_valid;
			r.best_slot        = sel_slot;
			r.best_version     = sel_version;
			expected_records.push_back(r);
			restart_record();
		end
	endfunction

	function automatic record_t build_record(logic [31:0] ver, logic [7:0] th, logic [7:0] hum,
		logic [15:0] gh, logic [7:0] tr, logic [15:0] gr);
		record_t     r;
		logic [31:0] c;
		r[31:0]    = TAG_WORD;
		r[39:32]   = crvs_pkg::SCHEMA_VALUE;
		r[71:40]   = ver;
		r[79:72]   = th;
		r[87:80]   = hum;
		r[103:88]  = gh;
		r[111:104] = tr;
		r[127:112] = gr;
		c = crvs_pkg::ALL_ONES;
		for (int i = 0; i < crvs_pkg::CRC_LEN; i++)
			c = crc32_step(c, r[8*i +: 8]);
		r[159:128] = c ^ crvs_pkg::ALL_ONES;
		return r;
	endfunction

	function automatic logic [31:0] pick_version();
		int unsigned k;
		k = $urandom_range(9);
		if (k < 5)
			return $urandom_range(15);
		else if (k < 8)
			return min_version_q + $urandom_range(4) - 2;
		else
			return $urandom;
	endfunction

	function automatic void report_mismatch(string what, crvs_pkg::crvs_out_t want,
		crvs_pkg::crvs_out_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t %s", $time, what);
			$display("  expected ok=%b st=%0d ver=%h th=%h hu=%h gh=%h tr=%h gr=%h best=%b/%0d/%h",
				want.record_ok, want.status, want.record_version, want.temperature_high,
				want.humidity_high, want.gas_high, want.temperature_rise, want.gas_rise,
				want.best_found, want.best_slot, want.best_version);
			$display("  actual   ok=%b st=%0d ver=%h th=%h hu=%h gh=%h tr=%h gr=%h best=%b/%0d/%h",
				got.record_ok, got.status, got.record_version, got.temperature_high,
				got.humidity_high, got.gas_high, got.temperature_rise, got.gas_rise,
				got.best_found, got.best_slot, got.best_version);
		end
	endfunction

	task automatic send_byte(logic [7:0] d, logic [2:0] slot, logic first);
		crvs_pkg::crvs_in_t it;
		it.data_byte     = d;
		it.slot_index    = slot;
		it.first_of_pass = first;
		byte_item  <= it;
		byte_valid <= 1'b1;
		do @(negedge clk); while (byte_stall !== 1'b0);
		@(posedge clk);
		predict_byte(it);
	endtask

	task automatic sender_gap();
		int unsigned n;
		if ($urandom_range(99) < gap_pct) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(3, 1);
			byte_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// pass_flags bit i is first_of_pass on byte i; slot_noise varies slot on inner bytes
	task automatic send_record(record_t r, logic [2:0] slot, pass_mask_t pass_flags,
		bit slot_noise);
		logic [2:0] s;
		for (int i = 0; i < crvs_pkg::REC_LEN; i++) begin
			s = slot;
			if (slot_noise && i != 0 && i != crvs_pkg::LAST_POS && $urandom_range(2) == 0)
				s = 3'($urandom_range(7));
			send_byte(r[8*i +: 8], s, pass_flags[i]);
			sender_gap();
		end
	endtask

	task automatic wait_idle();
		byte_valid <= 1'b0;
		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_version(logic [31:0] v);
		wait_idle();
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		min_version_q = v;
		cfg_we <= 1'b0;
	endtask

	task automatic send_random_record();
		record_t     r;
		logic [2:0]  slot;
		logic [7:0]  v;
		pass_mask_t  flags;
		int unsigned kind;
		int unsigned k;
		r = build_record(pick_version(), 8'($urandom), 8'($urandom), 16'($urandom),
			8'($urandom), 16'($urandom));
		kind = $urandom_range(99);
		if (kind < 8) begin
			k = $urandom_range(3);
			r[8*k +: 8] = r[8*k +: 8] ^ 8'($urandom_range(255, 1));
		end else if (kind < 16) begin
			v = 8'($urandom_range(255));
			r[39:32] = (v == crvs_pkg::SCHEMA_VALUE) ? 8'h00 : v;
		end else if (kind < 26) begin
			k = $urandom_range(19, 5);
			r[8*k +: 8] = r[8*k +: 8] ^ 8'($urandom_range(255, 1));
		end else if (kind < 32) begin
			r = {$urandom, $urandom, $urandom, $urandom, $urandom};
		end
		slot = ($urandom_range(9) < 7) ? 3'($urandom_range(crvs_pkg::RECORD_SLOTS - 1)) :
			3'($urandom_range(7));
		flags = '0;
		if ($urandom_range(3) == 0)
			flags = pass_mask_t'($urandom);
		flags[0] = ($urandom_range(6) == 0);
		send_record(r, slot, flags, $urandom_range(3) == 0);
	endtask

	task automatic test_directed_records();
		record_t r;
		gap_pct   = 0;
		stall_pct = 0;
		send_record(build_record(32'd1, 8'h00, 8'h00, 16'h0000, 8'h00, 16'h0000), 3'd0,
			pass_mask_t'(1), 1'b0);
		// below min_version: fields still reported
		send_record(build_record(32'd0, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF), 3'd1,
			'0, 1'b0);
		r = build_record(32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF);
		send_record(r, 3'd1, '0, 1'b0);
		// equal version does not take over
		send_record(r, 3'd0, '0, 1'b0);
		// bad tag on a pass start: selection cleared, nothing new selected
		r[7:0] = 8'h00;
		send_record(r, 3'd0, pass_mask_t'(1), 1'b0);
		send_record(build_record(32'd5, 8'h12, 8'h34, 16'h5678, 8'h9A, 16'hBCDE), 3'd7,
			'0, 1'b0);
		send_record(build_record(32'd3, 8'h5A, 8'hA5, 16'h0F0F, 8'hC3, 16'h3C3C), 3'd1,
			'0, 1'b0);
		// tag checked before schema
		r = build_record(32'd7, 8'h01, 8'h02, 16'h0304, 8'h05, 16'h0607);
		r[31:24] = 8'h00;
		r[39:32] = 8'h00;
		send_record(r, 3'd0, '0, 1'b0);
		// schema checked before CRC
		r = build_record(32'd8, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF);
		r[39:32] = 8'hFF;
		r[159:152] = r[159:152] ^ 8'h80;
		send_record(r, 3'd0, '0, 1'b0);
		r = build_record(32'd9, 8'h11, 8'h22, 16'h3344, 8'h55, 16'h6677);
		r[159:152] = r[159:152] ^ 8'h80;
		send_record(r, 3'd1, '0, 1'b0);
		// CRC checked before version
		r = build_record(32'd0, 8'h80, 8'h40, 16'h8001, 8'h20, 16'h1008);
		r[135:128] = r[135:128] ^ 8'h01;
		send_record(r, 3'd0, '0, 1'b0);
		// pass flag away from byte 0 is ignored
		send_record(build_record(32'd9, 8'h7F, 8'hFE, 16'h7FFF, 8'h01, 16'h8000), 3'd0,
			pass_mask_t'(1 << 10), 1'b0);
		send_record(build_record(32'd10, 8'h33, 8'hCC, 16'hAAAA, 8'h55, 16'h5555), 3'd1,
			'0, 1'b1);
	endtask

	task automatic test_min_version_extremes();
		write_min_version(32'd0);
		send_record(build_record(32'd0, 8'h01, 8'h02, 16'h0003, 8'h04, 16'h0005), 3'd0,
			pass_mask_t'(1), 1'b0);
		send_record(build_record(32'd0, 8'h06, 8'h07, 16'h0008, 8'h09, 16'h000A), 3'd1,
			'0, 1'b0);
		write_min_version(32'hFFFF_FFFF);
		send_record(build_record(32'hFFFF_FFFE, 8'hEE, 8'hDD, 16'hCCBB, 8'hAA, 16'h9988), 3'd1,
			'0, 1'b0);
		send_record(build_record(32'hFFFF_FFFF, 8'h00, 8'hFF, 16'h00FF, 8'hFF, 16'hFF00), 3'd1,
			'0, 1'b0);
	endtask

	task automatic test_random_traffic();
		logic [31:0] min_set [5];
		int unsigned gaps [5];
		int unsigned stalls [5];
		min_set = '{32'd1, 32'd0, 32'h0, 32'hFFFF_FFFF, 32'd6};
		min_set[2] = $urandom;
		gaps   = '{0, 25, 50, 10, 35};
		stalls = '{0, 25, 45, 10, 30};
		for (int p = 0; p < 5; p++) begin
			write_min_version(min_set[p]);
			gap_pct   = gaps[p];
			stall_pct = stalls[p];
			repeat (9) send_random_record();
		end
	endtask

	task automatic test_result_hold();
		write_min_version(32'd1);
		gap_pct   = 0;
		stall_pct = 0;
		hold_req  = 1'b1;
		repeat (4)
			send_record(build_record($urandom_range(100, 1), 8'($urandom), 8'($urandom),
				16'($urandom), 8'($urandom), 16'($urandom)),
				3'($urandom_range(crvs_pkg::RECORD_SLOTS - 1)), '0, 1'b0);
	endtask

	// result side: random stalls, plus one long hold on request
	initial begin
		int unsigned n;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				res_stall <= 1'b0;
			end else if ($urandom_range(99) < stall_pct) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		crvs_pkg::crvs_out_t want;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (res_valid === 1'b1 && res_stall === 1'b0) begin
				if (expected_records.size() == 0) begin
					report_mismatch("result with none expected", '0, res_item);
				end else begin
					want = expected_records.pop_front();
					if (res_item.record_ok !== want.record_ok ||
						res_item.status !== want.status ||
						res_item.record_version !== want.record_version ||
						res_item.temperature_high !== want.temperature_high ||
						res_item.humidity_high !== want.humidity_high ||
						res_item.gas_high !== want.gas_high ||
						res_item.temperature_rise !== want.temperature_rise ||
						res_item.gas_rise !== want.gas_rise ||
						res_item.best_found !== want.best_found ||
						res_item.best_slot !== want.best_slot ||
						res_item.best_version !== want.best_version)
						report_mismatch("result mismatch", want, res_item);
				end
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		byte_item  = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		min_version_q = crvs_pkg::MIN_VERSION_RESET;
		sel_valid     = 1'b0;
		sel_slot      = '0;
		sel_version   = '0;
		restart_record();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_records();
		test_min_version_extremes();
		test_random_traffic();
		test_result_hold();

		wait_idle();
		if (mismatches == 0)
			$display("** config_record_validate_select: PASSED **");
		else
			$display("** config_record_validate_select: FAILED **");
		$finish;
	end

endmodule
